/* hw/rtl/fcbc_pkg.sv */
// ----------------------------------------------------------------------------
// fcbc_pkg: shared types, constants and s-box tables
// Block and key widths, round count, the four byte s-boxes and the round mix.
// ----------------------------------------------------------------------------
`default_nettype none
package fcbc_pkg;

   localparam int BLOCK_W   = 64;
   localparam int HALF_W    = 32;
   localparam int KEY_W     = 64;
   localparam int KBITS_W   = 56;
   localparam int ROT_AMT   = 11;
   localparam int ROUNDS    = 16;
   localparam int RIDX_W    = 4;

   localparam logic ACT_ENCRYPT = 1'b0;
   localparam logic ACT_DECRYPT = 1'b1;

   typedef logic [HALF_W-1:0] half_type;
   typedef logic [7:0]        sbyte_type;

   // payload travelling with each pipeline stage
   typedef struct packed {
      logic     action;
      half_type left;
      half_type right;
      logic     last;
   } stage_type;

   localparam sbyte_type TAB_A [256] = '{
      8'hEA,8'h7F,8'hB2,8'h64,8'h9D,8'hB0,8'hD9,8'h11,8'hCD,8'h86,8'h86,8'h91,8'h0A,8'hB2,8'h93,8'h06,
      8'h0E,8'h06,8'hD2,8'h65,8'h73,8'hC5,8'h28,8'h60,8'hF2,8'h20,8'hB5,8'h38,8'h7E,8'hDA,8'h9F,8'hE3,
      8'hD2,8'hCF,8'hC4,8'h3C,8'h61,8'hFF,8'h4A,8'h4A,8'h35,8'hAC,8'hAA,8'h5F,8'h2B,8'hBB,8'hBC,8'h53,
      8'h4E,8'h9D,8'h78,8'hA3,8'hDC,8'h09,8'h32,8'h10,8'hC6,8'h6F,8'h66,8'hD6,8'hAB,8'hA9,8'hAF,8'hFD,
      8'h3B,8'h95,8'hE8,8'h34,8'h9A,8'h81,8'h72,8'h80,8'h9C,8'hF3,8'hEC,8'hDA,8'h9F,8'h26,8'h76,8'h15,
      8'h3E,8'h55,8'h4D,8'hDE,8'h84,8'hEE,8'hAD,8'hC7,8'hF1,8'h6B,8'h3D,8'hD3,8'h04,8'h49,8'hAA,8'h24,
      8'h0B,8'h8A,8'h83,8'hBA,8'hFA,8'h85,8'hA0,8'hA8,8'hB1,8'hD4,8'h01,8'hD8,8'h70,8'h64,8'hF0,8'h51,
      8'hD2,8'hC3,8'hA7,8'h75,8'h8C,8'hA5,8'h64,8'hEF,8'h10,8'h4E,8'hB7,8'hC6,8'h61,8'h03,8'hEB,8'h44,
      8'h3D,8'hE5,8'hB3,8'h5B,8'hAE,8'hD5,8'hAD,8'h1D,8'hFA,8'h5A,8'h1E,8'h33,8'hAB,8'h93,8'hA2,8'hB7,
      8'hE7,8'hA8,8'h45,8'hA4,8'hCD,8'h29,8'h63,8'h44,8'hB6,8'h69,8'h7E,8'h2E,8'h62,8'h03,8'hC8,8'hE0,
      8'h17,8'hBB,8'hC7,8'hF3,8'h3F,8'h36,8'hBA,8'h71,8'h8E,8'h97,8'h65,8'h60,8'h69,8'hB6,8'hF6,8'hE6,
      8'h6E,8'hE0,8'h81,8'h59,8'hE8,8'hAF,8'hDD,8'h95,8'h22,8'h99,8'hFD,8'h63,8'h19,8'h74,8'h61,8'hB1,
      8'hB6,8'h5B,8'hAE,8'h54,8'hB3,8'h70,8'hFF,8'hC6,8'h3B,8'h3E,8'hC1,8'hD7,8'hE1,8'h0E,8'h76,8'hE5,
      8'h36,8'h4F,8'h59,8'hC7,8'h08,8'h6E,8'h82,8'hA6,8'h93,8'hC4,8'hAA,8'h26,8'h49,8'hE0,8'h21,8'h64,
      8'h07,8'h9F,8'h64,8'h81,8'h9C,8'hBF,8'hF9,8'hD1,8'h43,8'hF8,8'hB6,8'hB9,8'hF1,8'h24,8'h75,8'h03,
      8'hE4,8'hB0,8'h99,8'h46,8'h3D,8'hF5,8'hD1,8'h39,8'h72,8'h12,8'hF6,8'hBA,8'h0C,8'h0D,8'h42,8'h2E
   };

   localparam sbyte_type TAB_B [256] = '{
      8'h77,8'h14,8'hA6,8'hFE,8'hB2,8'h5E,8'h8C,8'h3E,8'h67,8'h6C,8'hA1,8'h0D,8'hC2,8'hA2,8'hC1,8'h85,
      8'h6C,8'h7B,8'h67,8'hC6,8'h23,8'hE3,8'hF2,8'h89,8'h50,8'h9C,8'h03,8'hB7,8'h73,8'hE6,8'hE1,8'h39,
      8'h31,8'h2C,8'h27,8'h9F,8'hA5,8'h69,8'h44,8'hD6,8'h23,8'h83,8'h98,8'h7D,8'h3C,8'hB4,8'h2D,8'h99,
      8'h1C,8'h1F,8'h8C,8'h20,8'h03,8'h7C,8'h5F,8'hAD,8'hF4,8'hFA,8'h95,8'hCA,8'h76,8'h44,8'hCD,8'hB6,
      8'hB8,8'hA1,8'hA1,8'hBE,8'h9E,8'h54,8'h8F,8'h0B,8'h16,8'h74,8'h31,8'h8A,8'h23,8'h17,8'h04,8'hFA,
      8'h79,8'h84,8'hB1,8'hF5,8'h13,8'hAB,8'hB5,8'h2E,8'hAA,8'h0C,8'h60,8'h6B,8'h5B,8'hC4,8'h4B,8'hBC,
      8'hE2,8'hAF,8'h45,8'h73,8'hFA,8'hC9,8'h49,8'hCD,8'h00,8'h92,8'h7D,8'h97,8'h7A,8'h18,8'h60,8'h3D,
      8'hCF,8'h5B,8'hDE,8'hC6,8'hE2,8'hE6,8'hBB,8'h8B,8'h06,8'hDA,8'h08,8'h15,8'h1B,8'h88,8'h6A,8'h17,
      8'h89,8'hD0,8'hA9,8'hC1,8'hC9,8'h70,8'h6B,8'hE5,8'h43,8'hF4,8'h68,8'hC8,8'hD3,8'h84,8'h28,8'h0A,
      8'h52,8'h66,8'hA3,8'hCA,8'hF2,8'hE3,8'h7F,8'h7A,8'h31,8'hF7,8'h88,8'h94,8'h5E,8'h9C,8'h63,8'hD5,
      8'h24,8'h66,8'hFC,8'hB3,8'h57,8'h25,8'hBE,8'h89,8'h44,8'hC4,8'hE0,8'h8F,8'h23,8'h3C,8'h12,8'h52,
      8'hF5,8'h1E,8'hF4,8'hCB,8'h18,8'h33,8'h1F,8'hF8,8'h69,8'h10,8'h9D,8'hD3,8'hF7,8'h28,8'hF8,8'h30,
      8'h05,8'h5E,8'h32,8'hC0,8'hD5,8'h19,8'hBD,8'h45,8'h8B,8'h5B,8'hFD,8'hBC,8'hE2,8'h5C,8'hA9,8'h96,
      8'hEF,8'h70,8'hCF,8'hC2,8'h2A,8'hB3,8'h61,8'hAD,8'h80,8'h48,8'h81,8'hB7,8'h1D,8'h43,8'hD9,8'hD7,
      8'h45,8'hF0,8'hD8,8'h8A,8'h59,8'h7C,8'h57,8'hC1,8'h79,8'hC7,8'h34,8'hD6,8'h43,8'hDF,8'hE4,8'h78,
      8'h16,8'h06,8'hDA,8'h92,8'h76,8'h51,8'hE1,8'hD4,8'h70,8'h03,8'hE0,8'h2F,8'h96,8'h91,8'h82,8'h80
   };

   localparam sbyte_type TAB_C [256] = '{
      8'hF0,8'h37,8'h24,8'h53,8'h2A,8'h03,8'h83,8'h86,8'hD1,8'hEC,8'h50,8'hF0,8'h42,8'h78,8'h2F,8'h6D,
      8'hBF,8'h80,8'h87,8'h27,8'h95,8'hE2,8'hC5,8'h5D,8'hF9,8'h6F,8'hDB,8'hB4,8'h65,8'h6E,8'hE7,8'h24,
      8'hC8,8'h1A,8'hBB,8'h49,8'hB5,8'h0A,8'h7D,8'hB9,8'hE8,8'hDC,8'hB7,8'hD9,8'h45,8'h20,8'h1B,8'hCE,
      8'h59,8'h9D,8'h6B,8'hBD,8'h0E,8'h8F,8'hA3,8'hA9,8'hBC,8'h74,8'hA6,8'hF6,8'h7F,8'h5F,8'hB1,8'h68,
      8'h84,8'hBC,8'hA9,8'hFD,8'h55,8'h50,8'hE9,8'hB6,8'h13,8'h5E,8'h07,8'hB8,8'h95,8'h02,8'hC0,8'hD0,
      8'h6A,8'h1A,8'h85,8'hBD,8'hB6,8'hFD,8'hFE,8'h17,8'h3F,8'h09,8'hA3,8'h8D,8'hFB,8'hED,8'hDA,8'h1D,
      8'h6D,8'h1C,8'h6C,8'h01,8'h5A,8'hE5,8'h71,8'h3E,8'h8B,8'h6B,8'hBE,8'h29,8'hEB,8'h12,8'h19,8'h34,
      8'hCD,8'hB3,8'hBD,8'h35,8'hEA,8'h4B,8'hD5,8'hAE,8'h2A,8'h79,8'h5A,8'hA5,8'h32,8'h12,8'h7B,8'hDC,
      8'h2C,8'hD0,8'h22,8'h4B,8'hB1,8'h85,8'h59,8'h80,8'hC0,8'h30,8'h9F,8'h73,8'hD3,8'h14,8'h48,8'h40,
      8'h07,8'h2D,8'h8F,8'h80,8'h0F,8'hCE,8'h0B,8'h5E,8'hB7,8'h5E,8'hAC,8'h24,8'h94,8'h4A,8'h18,8'h15,
      8'h05,8'hE8,8'h02,8'h77,8'hA9,8'hC7,8'h40,8'h45,8'h89,8'hD1,8'hEA,8'hDE,8'h0C,8'h79,8'h2A,8'h99,
      8'h6C,8'h3E,8'h95,8'hDD,8'h8C,8'h7D,8'hAD,8'h6F,8'hDC,8'hFF,8'hFD,8'h62,8'h47,8'hB3,8'h21,8'h8A,
      8'hEC,8'h8E,8'h19,8'h18,8'hB4,8'h6E,8'h3D,8'hFD,8'h74,8'h54,8'h1E,8'h04,8'h85,8'hD8,8'hBC,8'h1F,
      8'h56,8'hE7,8'h3A,8'h56,8'h67,8'hD6,8'hC8,8'hA5,8'hF3,8'h8E,8'hDE,8'hAE,8'h37,8'h49,8'hB7,8'hFA,
      8'hC8,8'hF4,8'h1F,8'hE0,8'h2A,8'h9B,8'h15,8'hD1,8'h34,8'h0E,8'hB5,8'hE0,8'h44,8'h78,8'h84,8'h59,
      8'h56,8'h68,8'h77,8'hA5,8'h14,8'h06,8'hF5,8'h2F,8'h8C,8'h8A,8'h73,8'h80,8'h76,8'hB4,8'h10,8'h86
   };

   localparam sbyte_type TAB_D [256] = '{
      8'hA9,8'h2A,8'h48,8'h51,8'h84,8'h7E,8'h49,8'hE2,8'hB5,8'hB7,8'h42,8'h33,8'h7D,8'h5D,8'hA6,8'h12,
      8'h44,8'h48,8'h6D,8'h28,8'hAA,8'h20,8'h6D,8'h57,8'hD6,8'h6B,8'h5D,8'h72,8'hF0,8'h92,8'h5A,8'h1B,
      8'h53,8'h80,8'h24,8'h70,8'h9A,8'hCC,8'hA7,8'h66,8'hA1,8'h01,8'hA5,8'h41,8'h97,8'h41,8'h31,8'h82,
      8'hF1,8'h14,8'hCF,8'h53,8'h0D,8'hA0,8'h10,8'hCC,8'h2A,8'h7D,8'hD2,8'hBF,8'h4B,8'h1A,8'hDB,8'h16,
      8'h47,8'hF6,8'h51,8'h36,8'hED,8'hF3,8'hB9,8'h1A,8'hA7,8'hDF,8'h29,8'h43,8'h01,8'h54,8'h70,8'hA4,
      8'hBF,8'hD4,8'h0B,8'h53,8'h44,8'h60,8'h9E,8'h23,8'hA1,8'h18,8'h68,8'h4F,8'hF0,8'h2F,8'h82,8'hC2,
      8'h2A,8'h41,8'hB2,8'h42,8'h0C,8'hED,8'h0C,8'h1D,8'h13,8'h3A,8'h3C,8'h6E,8'h35,8'hDC,8'h60,8'h65,
      8'h85,8'hE9,8'h64,8'h02,8'h9A,8'h3F,8'h9F,8'h87,8'h96,8'hDF,8'hBE,8'hF2,8'hCB,8'hE5,8'h6C,8'hD4,
      8'h5A,8'h83,8'hBF,8'h92,8'h1B,8'h94,8'h00,8'h42,8'hCF,8'h4B,8'h00,8'h75,8'hBA,8'h8F,8'h76,8'h5F,
      8'h5D,8'h3A,8'h4D,8'h09,8'h12,8'h08,8'h38,8'h95,8'h17,8'hE4,8'h01,8'h1D,8'h4C,8'hA9,8'hCC,8'h85,
      8'h82,8'h4C,8'h9D,8'h2F,8'h3B,8'h66,8'hA1,8'h34,8'h10,8'hCD,8'h59,8'h89,8'hA5,8'h31,8'hCF,8'h05,
      8'hC8,8'h84,8'hFA,8'hC7,8'hBA,8'h4E,8'h8B,8'h1A,8'h19,8'hF1,8'hA1,8'h3B,8'h18,8'h12,8'h17,8'hB0,
      8'h98,8'h8D,8'h0B,8'h23,8'hC3,8'h3A,8'h2D,8'h20,8'hDF,8'h13,8'hA0,8'hA8,8'h4C,8'h0D,8'h6C,8'h2F,
      8'h47,8'h13,8'h13,8'h52,8'h1F,8'h2D,8'hF5,8'h79,8'h3D,8'hA2,8'h54,8'hBD,8'h69,8'hC8,8'h6B,8'hF3,
      8'h05,8'h28,8'hF1,8'h16,8'h46,8'h40,8'hB0,8'h11,8'hD3,8'hB7,8'h95,8'h49,8'hCF,8'hC3,8'h1D,8'h8F,
      8'hD8,8'hE1,8'h73,8'hDB,8'hAD,8'hC8,8'hC9,8'hA9,8'hA1,8'hC2,8'hC5,8'hE3,8'hBA,8'hFC,8'h0E,8'h25
   };

   // round function: four byte lookups, placed and rotated, xored together
   function automatic half_type mix(input half_type half, input half_type sk);
      half_type  t;
      sbyte_type a, b, c, d;
      t = half ^ sk;
      a = TAB_A[t[31:24]];
      b = TAB_B[t[23:16]];
      c = TAB_C[t[15:8]];
      d = TAB_D[t[7:0]];
      return {21'd0, a, 3'd0} ^ {b[4:0], 24'd0, b[7:5]} ^ {13'd0, c, 11'd0}
             ^ {5'd0, d, 19'd0};
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/fcbc_if.sv */
// ----------------------------------------------------------------------------
// fcbc channel interfaces
// Valid/ready channels for blocks in, blocks out and key writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface fcbc_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [63:0] block_in;
   logic        last_in;
   modport source (output valid, action, block_in, last_in, input ready);
   modport sink   (input valid, action, block_in, last_in, output ready);
endinterface

interface fcbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_out;
   logic        last_out;
   modport source (output valid, block_out, last_out, input ready);
   modport sink   (input valid, block_out, last_out, output ready);
endinterface

interface fcbc_csr_if;
   logic        valid;
   logic        ready;
   logic [63:0] key_word;
   modport source (output valid, key_word, input ready);
   modport sink   (input valid, key_word, output ready);
endinterface
`default_nettype wire

/* hw/rtl/fcbc_key_sched.sv */
// ----------------------------------------------------------------------------
// fcbc_key_sched: key bit packing and registered subkey table
// Drops parity bits and derives the sixteen round subkeys on a key write.
// ----------------------------------------------------------------------------
`default_nettype none
module fcbc_key_sched (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire logic                                           wr_en,
   input  wire logic [fcbc_pkg::KEY_W-1:0]                     wr_key,
   output      fcbc_pkg::half_type [fcbc_pkg::ROUNDS-1:0]      subkeys
);
   import fcbc_pkg::*;

   logic [KBITS_W-1:0] kbits;
   half_type [ROUNDS-1:0] sk_ff, sk_in;

   // pack seven key bits from each byte, first byte on top
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         kbits[KBITS_W-1-7*i -: 7] = wr_key[KEY_W-1-8*i -: 7];
      end
   end

   // subkey n is the low word after n rotations by eleven
   always_comb begin
      for (int n = 0; n < ROUNDS; n++) begin
         sk_in[n] = 32'({kbits, kbits} >> ((n * ROT_AMT) % KBITS_W));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sk_ff <= '0;
      end else if (wr_en) begin
         sk_ff <= sk_in;
      end
   end

   assign subkeys = sk_ff;
endmodule
`default_nettype wire

/* hw/rtl/fcbc_round.sv */
// ----------------------------------------------------------------------------
// fcbc_round: one registered feistel round pair
// Applies two rounds, order and subkeys chosen by the action bit.
// ----------------------------------------------------------------------------
`default_nettype none
module fcbc_round #(
   parameter int STAGE = 0
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      advance,
   input  wire logic                                      in_valid,
   input  wire fcbc_pkg::stage_type                       in_data,
   input  wire fcbc_pkg::half_type [fcbc_pkg::ROUNDS-1:0] subkeys,
   output      logic                                      out_valid,
   output      fcbc_pkg::stage_type                       out_data
);
   import fcbc_pkg::*;

   localparam int ENC_K0 = 2 * STAGE;
   localparam int DEC_K0 = ROUNDS - 1 - 2 * STAGE;

   logic      valid_ff;
   stage_type data_ff, data_in;
   half_type  l1, r1;

   // encrypt: right feeds left first; decrypt: left feeds right first
   always_comb begin
      data_in = in_data;
      if (in_data.action == ACT_ENCRYPT) begin
         l1 = in_data.left ^ mix(in_data.right, subkeys[ENC_K0]);
         r1 = in_data.right ^ mix(l1, subkeys[ENC_K0 + 1]);
      end else begin
         r1 = in_data.right ^ mix(in_data.left, subkeys[DEC_K0]);
         l1 = in_data.left ^ mix(r1, subkeys[DEC_K0 - 1]);
      end
      data_in.left  = l1;
      data_in.right = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

/* hw/rtl/fcrypt_block_cipher_top.sv */
// ----------------------------------------------------------------------------
// fcrypt_block_cipher_top: pipelined 64-bit feistel block cipher
// ----------------------------------------------------------------------------
// Channels: req carries one block word (action, block_in, last_in), rsp
// returns one word (block_out, last_out) per block, in order. csr writes the
// 64-bit key; all sixteen subkeys are registered on the write and in place
// in the cycle after it. The user must write keys only while no block is
// in flight; the block itself does not enforce this.
// Pipeline: eight register stages, two rounds each; the last is the output
// register. Throughput: one block per cycle while rsp.ready is high.
// Stalls: when rsp.ready is low the whole pipeline holds, except that bubbles
// are squeezed out, so req.ready stays high while any stage is empty.
// Reset: clears all stage valid bits and sets the subkeys to zero.
// ----------------------------------------------------------------------------
`default_nettype none
module fcrypt_block_cipher_top (
   input  wire logic clock,
   input  wire logic reset,
   fcbc_req_if.sink  req,
   fcbc_rsp_if.source rsp,
   fcbc_csr_if.sink  csr
);
   import fcbc_pkg::*;

   // one stage per round pair
   localparam int STAGES = ROUNDS / 2;

   half_type [ROUNDS-1:0] subkeys;
   logic      [STAGES:0] vld;
   stage_type [STAGES:0] dat;
   logic      [STAGES-1:0] adv;

   // key schedule
   assign csr.ready = 1'b1;
   fcbc_key_sched u_key (
      .clock, .reset, .wr_en(csr.valid), .wr_key(csr.key_word), .subkeys
   );

   // stage zero is the request word itself
   assign vld[0]        = req.valid;
   assign dat[0].action = req.action;
   assign dat[0].left   = req.block_in[63:32];
   assign dat[0].right  = req.block_in[31:0];
   assign dat[0].last   = req.last_in;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      adv[STAGES-1] = rsp.ready | ~vld[STAGES];
      for (int s = STAGES-2; s >= 0; s--) begin
         adv[s] = adv[s+1] | ~vld[s+1];
      end
   end
   assign req.ready = adv[0];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      fcbc_round #(.STAGE(g)) u_round (
         .clock, .reset, .advance(adv[g]), .in_valid(vld[g]), .in_data(dat[g]),
         .subkeys, .out_valid(vld[g+1]), .out_data(dat[g+1])
      );
   end

   assign rsp.valid     = vld[STAGES];
   assign rsp.block_out = {dat[STAGES].left, dat[STAGES].right};
   assign rsp.last_out  = dat[STAGES].last;
endmodule
`default_nettype wire

/* hw/rtl/fcbc_checker.sv */
// ----------------------------------------------------------------------------
// fcbc_checker: port-level checks for the cipher top level
// Handshake hold rules and pipeline occupancy behaviour.
// ----------------------------------------------------------------------------
`default_nettype none
module fcbc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_block_out,
   input wire logic        csr_ready
);
   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_out))
      else $error("rsp word changed under stall");

   // no result can be shown right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   // an empty output stage never stalls the request side
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   // key port always takes writes
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr not ready");
endmodule

bind fcrypt_block_cipher_top fcbc_checker u_fcbc_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_block_out(rsp.block_out),
   .csr_ready(csr.ready)
);
`default_nettype wire
